### src/blank_run_entab_core_assert.svh
// Assertion macros for blank_run_entab_core.
// Expects signals clk and rst_n in the including scope.
`ifndef BLANK_RUN_ENTAB_CORE_ASSERT_SVH
`define BLANK_RUN_ENTAB_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BRE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bre assertion failed");
`define BRE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bre reset assertion failed");
`else
`define BRE_ASSERT(lbl, prop)
`define BRE_ASSERT_RST(lbl, prop)
`endif

`endif

### src/bre_pkg.sv
// Package for blank_run_entab_core: character codes, widths, queue command type.
// No dependencies.
`timescale 1ns / 1ps
package bre_pkg;
  localparam int MAX_TAB_WIDTH = 16;
  localparam int MIN_TAB_WIDTH = 2;
  localparam int TW_W = 5;
  localparam int POS_W = $clog2(MAX_TAB_WIDTH);
  localparam logic [TW_W-1:0] RESET_TAB_WIDTH = TW_W'(8);
  localparam logic [7:0] CH_BLANK = 8'd32;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [POS_W-1:0] n_blanks;
    logic             has_char;
    logic [7:0]       ch;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] stop;
    logic [POS_W-1:0] pend;
  } front_stat_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;
endpackage

### src/bre_front.sv
// Front end: accepts items, tracks tab stop column and pending blanks,
// pushes output commands into the queue. Depends on bre_pkg.
`timescale 1ns / 1ps
module bre_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [7:0]             in_char,
  input  logic                   in_eoi,
  input  logic [bre_pkg::TW_W-1:0] tab_width,
  input  logic                   q_full,
  output logic                   in_stall,
  output logic                   push,
  output bre_pkg::cmd_t          cmd,
  output bre_pkg::front_stat_t   stat
);
  import bre_pkg::*;

  logic [POS_W-1:0] stop_r, stop_nxt;
  logic [POS_W-1:0] pend_r, pend_nxt;
  logic [TW_W-1:0]  w_eff;
  logic [TW_W-1:0]  stop_inc;
  logic             at_stop;
  logic             acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign stat     = '{stop: stop_r, pend: pend_r};

  always_comb begin
    if (tab_width < TW_W'(MIN_TAB_WIDTH)) begin
      w_eff = TW_W'(MIN_TAB_WIDTH);
    end else if (tab_width > TW_W'(MAX_TAB_WIDTH)) begin
      w_eff = TW_W'(MAX_TAB_WIDTH);
    end else begin
      w_eff = tab_width;
    end
    stop_inc = TW_W'(stop_r) + TW_W'(1);
    at_stop  = (stop_inc >= w_eff);
  end

  always_comb begin
    stop_nxt     = stop_r;
    pend_nxt     = pend_r;
    push         = 1'b0;
    cmd.n_blanks = '0;
    cmd.has_char = 1'b1;
    cmd.ch       = in_char;
    if (acc) begin
      if (in_eoi) begin
        cmd.n_blanks = pend_r;
        cmd.has_char = 1'b0;
        push         = (pend_r != '0);
        stop_nxt     = '0;
        pend_nxt     = '0;
      end else begin
        unique case (in_char)
          CH_BLANK: begin
            if (at_stop) begin
              push     = 1'b1;
              cmd.ch   = (pend_r == '0) ? CH_BLANK : CH_TAB;
              stop_nxt = '0;
              pend_nxt = '0;
            end else begin
              stop_nxt = stop_inc[POS_W-1:0];
              pend_nxt = pend_r + POS_W'(1);
            end
          end
          CH_TAB: begin
            push     = 1'b1;
            cmd.ch   = CH_TAB;
            stop_nxt = '0;
            pend_nxt = '0;
          end
          default: begin
            push         = 1'b1;
            cmd.n_blanks = pend_r;
            pend_nxt     = '0;
            if (in_char == CH_NEWLINE || at_stop) begin
              stop_nxt = '0;
            end else begin
              stop_nxt = stop_inc[POS_W-1:0];
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= '0;
      pend_r <= '0;
    end else begin
      stop_r <= stop_nxt;
      pend_r <= pend_nxt;
    end
  end
endmodule

### src/bre_fifo.sv
// Short command queue between front and back ends.
// Depends on bre_pkg.
`timescale 1ns / 1ps
module bre_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bre_pkg::cmd_t   wr_cmd,
  input  logic            pop,
  output bre_pkg::cmd_t   rd_cmd,
  output bre_pkg::q_stat_t stat
);
  import bre_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end
endmodule

### src/bre_back.sv
// Back end: expands queued commands into result items through an output register.
// Depends on bre_pkg.
`timescale 1ns / 1ps
module bre_back (
  input  logic          clk,
  input  logic          rst_n,
  input  bre_pkg::cmd_t rd_cmd,
  input  logic          q_empty,
  output logic          pop,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          out_last
);
  import bre_pkg::*;

  logic             cur_valid_r, cur_valid_nxt;
  logic [POS_W-1:0] cur_cnt_r, cur_cnt_nxt;
  logic             cur_has_r, cur_has_nxt;
  logic [7:0]       cur_ch_r, cur_ch_nxt;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;
  logic             load_out;
  logic             cur_fin;

  assign load_out  = !out_valid_r || !out_stall;
  assign cur_fin   = (cur_cnt_r == '0) || (cur_cnt_r == POS_W'(1) && !cur_has_r);
  assign pop       = !q_empty && (!cur_valid_r || (load_out && cur_fin));
  assign busy      = cur_valid_r;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_cnt_nxt   = cur_cnt_r;
    cur_has_nxt   = cur_has_r;
    cur_ch_nxt    = cur_ch_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_cnt_nxt   = rd_cmd.n_blanks;
      cur_has_nxt   = rd_cmd.has_char;
      cur_ch_nxt    = rd_cmd.ch;
    end else if (load_out && cur_valid_r) begin
      if (cur_fin) begin
        cur_valid_nxt = 1'b0;
      end else begin
        cur_cnt_nxt = cur_cnt_r - POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (load_out) out_valid_r <= cur_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_cnt_r <= cur_cnt_nxt;
    cur_has_r <= cur_has_nxt;
    cur_ch_r  <= cur_ch_nxt;
    if (load_out && cur_valid_r) begin
      if (cur_cnt_r != '0) begin
        out_char_r <= CH_BLANK;
        out_last_r <= cur_fin;
      end else begin
        out_char_r <= cur_ch_r;
        out_last_r <= 1'b1;
      end
    end
  end
endmodule

### src/blank_run_entab_core.sv
// Top level of the blank-to-tab converter: front end, command queue, back end.
// Depends on bre_pkg, bre_front, bre_fifo, bre_back, blank_run_entab_core_assert.svh.
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | in_char_in[7:0], in_end_of_input
//   out     | out_valid/out_stall| out_char_out[7:0], out_last_of_run
//   cfg     | cfg_valid/cfg_ready| cfg_tab_width[4:0]
//
// One item accepted per cycle while the 4-entry command queue has room.
// The back end emits one result per cycle unless out_stall holds the output register.
// An accepted item's results pass the command queue, the current-command register and the output register.
// Reset: column and pending blanks zero, tab width 8, queue and output empty.
// in_stall rises only when the queue is full; out_stall holds the output register.
`timescale 1ns / 1ps
`include "blank_run_entab_core_assert.svh"
module blank_run_entab_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_char_in,
  input  logic                     in_end_of_input,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_char_out,
  output logic                     out_last_of_run,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [bre_pkg::TW_W-1:0] cfg_tab_width
);
  import bre_pkg::*;

  logic [TW_W-1:0] tab_width_r;
  cmd_t            wr_cmd, rd_cmd;
  logic            push, pop, busy;
  front_stat_t     fstat;
  q_stat_t         qstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r <= RESET_TAB_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      tab_width_r <= cfg_tab_width;
    end
  end

  bre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_char   (in_char_in),
    .in_eoi    (in_end_of_input),
    .tab_width (tab_width_r),
    .q_full    (qstat.full),
    .in_stall  (in_stall),
    .push      (push),
    .cmd       (wr_cmd),
    .stat      (fstat)
  );

  bre_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .stat   (qstat)
  );

  bre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_cmd    (rd_cmd),
    .q_empty   (qstat.empty),
    .pop       (pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char_out),
    .out_last  (out_last_of_run)
  );

  `BRE_ASSERT(a_pend_le_stop, fstat.pend <= fstat.stop)
  `BRE_ASSERT(a_q_grow, push && !pop && !qstat.full |=> qstat.count == $past(qstat.count) + 1'b1)
  `BRE_ASSERT(a_mid_run_busy, out_valid && !out_last_of_run |-> busy)
  `BRE_ASSERT_RST(a_rst_out_idle, !rst_n |=> !out_valid && qstat.empty)
endmodule

### tb/sv/testbench.sv
// Self-checking testbench for blank_run_entab_core: directed table, then random text phases.
// Depends on bre_pkg and blank_run_entab_core; an in-file predictor builds expected output.
`timescale 1ns / 1ps
module testbench;
  import bre_pkg::*;

  localparam int N_ROWS     = 27;
  localparam int RAND_ITEMS = 330;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t       kind;
    logic [7:0]      ch;
    logic            eoi;
    logic [TW_W-1:0] tw;
    bit              typed;
    int              n_res;
    logic [7:0]      last_ch;
  } row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      in_char_in = 8'h00;
  logic            in_end_of_input = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [7:0]      out_char_out;
  logic            out_last_of_run;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [TW_W-1:0] cfg_tab_width = RESET_TAB_WIDTH;

  // typed expectation travelling with the item on the input channel
  bit              item_typed = 1'b0;
  int              item_n_res = 0;
  logic [7:0]      item_last_ch = 8'h00;

  bit              tx_calm = 1'b0;
  bit              rx_calm = 1'b0;
  int              items_sent = 0;
  int              errors = 0;
  int              idle_cycles = 0;

  // predictor state
  logic [TW_W-1:0] tab_cols = RESET_TAB_WIDTH;
  int              col_pos = 0;
  int              held_blanks = 0;
  out_char_t       out_char_q[$];

  row_t dir_rows [N_ROWS] = '{
    '{ROW_ITEM, 8'hFF,      1'b1, '0,     1'b1, 0, 8'h00},
    '{ROW_ITEM, 8'h00,      1'b0, '0,     1'b1, 1, 8'h00},
    '{ROW_ITEM, 8'hFF,      1'b0, '0,     1'b1, 1, 8'hFF},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b1, 0, 8'h00},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b1, 0, 8'h00},
    '{ROW_ITEM, CH_NEWLINE, 1'b0, '0,     1'b1, 3, CH_NEWLINE},
    '{ROW_ITEM, CH_TAB,     1'b0, '0,     1'b1, 1, CH_TAB},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b1, 0, 8'h00},
    '{ROW_ITEM, CH_TAB,     1'b0, '0,     1'b1, 1, CH_TAB},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b1, 0, 8'h00},
    '{ROW_ITEM, CH_BLANK,   1'b1, '0,     1'b1, 1, CH_BLANK},
    '{ROW_ITEM, 8'h0D,      1'b0, '0,     1'b1, 1, 8'h0D},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b0, 0, 8'h00},
    '{ROW_ITEM, 8'h41,      1'b0, '0,     1'b0, 0, 8'h00},
    '{ROW_CFG,  8'h00,      1'b0, 5'd0,   1'b0, 0, 8'h00},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b0, 0, 8'h00},
    '{ROW_ITEM, 8'h61,      1'b0, '0,     1'b1, 1, 8'h61},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b1, 1, CH_BLANK},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b1, 0, 8'h00},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b1, 1, CH_TAB},
    '{ROW_CFG,  8'h00,      1'b0, 5'd31,  1'b0, 0, 8'h00},
    '{ROW_ITEM, 8'h7E,      1'b0, '0,     1'b1, 1, 8'h7E},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b1, 0, 8'h00},
    '{ROW_CFG,  8'h00,      1'b0, 5'd1,   1'b0, 0, 8'h00},
    '{ROW_ITEM, 8'h62,      1'b0, '0,     1'b0, 0, 8'h00},
    '{ROW_ITEM, CH_BLANK,   1'b0, '0,     1'b0, 0, 8'h00},
    '{ROW_CFG,  8'h00,      1'b0, 5'd16,  1'b0, 0, 8'h00}
  };

  blank_run_entab_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_out    (out_char_out),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_tab_width   (cfg_tab_width)
  );

  always #5 clk = ~clk;

  // blank-to-tab conversion of one item; results go to out_char_q when commit is set
  function automatic void entab_step(input logic [7:0] ch, input logic eoi, input bit commit);
    int         w;
    logic [7:0] res[$];
    w = int'(tab_cols);
    if (w < MIN_TAB_WIDTH) w = MIN_TAB_WIDTH;
    if (w > MAX_TAB_WIDTH) w = MAX_TAB_WIDTH;
    if (eoi) begin
      repeat (held_blanks) res.push_back(CH_BLANK);
      held_blanks = 0;
      col_pos = 0;
    end else if (ch == CH_BLANK) begin
      held_blanks++;
      col_pos++;
      if (col_pos >= w) begin
        res.push_back(held_blanks == 1 ? CH_BLANK : CH_TAB);
        held_blanks = 0;
        col_pos = 0;
      end
    end else if (ch == CH_TAB) begin
      held_blanks = 0;
      res.push_back(CH_TAB);
      col_pos = 0;
    end else begin
      repeat (held_blanks) res.push_back(CH_BLANK);
      held_blanks = 0;
      res.push_back(ch);
      if (ch == CH_NEWLINE) begin
        col_pos = 0;
      end else begin
        col_pos++;
        if (col_pos >= w) col_pos = 0;
      end
    end
    if (commit)
      foreach (res[i]) out_char_q.push_back('{res[i], i == res.size() - 1});
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tab_cols = cfg_tab_width;
      if (in_valid && !in_stall) begin
        entab_step(in_char_in, in_end_of_input, !item_typed);
        if (item_typed)
          for (int i = 0; i < item_n_res; i++)
            out_char_q.push_back(i == item_n_res - 1 ? out_char_t'{item_last_ch, 1'b1}
                                                     : out_char_t'{CH_BLANK, 1'b0});
      end
      if (out_valid && !out_stall) begin
        if (out_char_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result char=%02h last=%b", $time, out_char_out,
                   out_last_of_run);
        end else begin
          if (out_char_q[0].ch !== out_char_out) begin
            errors++;
            $display("%0t: char_out expected %02h actual %02h", $time, out_char_q[0].ch,
                     out_char_out);
          end
          if (out_char_q[0].last !== out_last_of_run) begin
            errors++;
            $display("%0t: last_of_run expected %b actual %b", $time, out_char_q[0].last,
                     out_last_of_run);
          end
          void'(out_char_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** blank_run_entab_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int stall_cycles;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall_cycles = rx_calm ? 0 : $urandom_range(0, 3);
      repeat (stall_cycles) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic eoi, input bit typed = 1'b0,
                           input int n_res = 0, input logic [7:0] last_ch = 8'h00);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char_in      <= ch;
    in_end_of_input <= eoi;
    item_typed      <= typed;
    item_n_res      <= n_res;
    item_last_ch    <= last_ch;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // pending blanks cause no result, so wait out the pipeline after the last expected char
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (out_char_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_tab_width(input logic [TW_W-1:0] w);
    drain();
    cfg_valid     <= 1'b1;
    cfg_tab_width <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_text_token;
    case ($urandom_range(0, 9))
      0, 1, 2: repeat ($urandom_range(1, 18)) send_item(CH_BLANK, 1'b0);
      3, 4:    repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(33, 126)), 1'b0);
      5:       send_item(CH_TAB, 1'b0);
      6:       send_item(CH_NEWLINE, 1'b0);
      7:       send_item(8'($urandom), $urandom_range(0, 7) == 0);
      8:       send_item(8'($urandom), 1'b1);
      default: send_item(8'($urandom_range(0, 31)), 1'b0);
    endcase
  endtask

  initial begin
    logic [TW_W-1:0] edge_widths [8];
    logic [TW_W-1:0] w;
    edge_widths = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd17, 5'd1, 5'd3, 5'd15};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_tab_width(dir_rows[i].tw);
      else
        send_item(dir_rows[i].ch, dir_rows[i].eoi, dir_rows[i].typed, dir_rows[i].n_res,
                  dir_rows[i].last_ch);
    end

    items_sent = 0;
    for (int ph = 0; items_sent < RAND_ITEMS; ph++) begin
      w = (ph < 8) ? edge_widths[ph] : TW_W'($urandom_range(0, 31));
      write_tab_width(w);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(10, 25))
        if (items_sent < RAND_ITEMS) send_text_token();
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && out_char_q.size() == 0) begin
      $display("** blank_run_entab_core: PASSED **");
    end else begin
      if (out_char_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, out_char_q.size());
      $display("** blank_run_entab_core: FAILED **");
    end
    $finish;
  end

endmodule
